// ----- rtl/rgb_to_framebuffer_pixel_packer_top_defines.svh -----
// ---------------------------------------------------------------------------
// rgb_to_framebuffer_pixel_packer_top_defines.svh
// Assertion macros shared by the pixel packer RTL.
// ---------------------------------------------------------------------------
`ifndef RGB_TO_FRAMEBUFFER_PIXEL_PACKER_TOP_DEFINES_SVH
`define RGB_TO_FRAMEBUFFER_PIXEL_PACKER_TOP_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication, checked out of reset
`define RFP_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pixel packer: implication check failed");
// Next-cycle implication, checked out of reset
`define RFP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pixel packer: next-cycle check failed");
`else
`define RFP_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define RFP_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

// ----- rtl/rgbfb_pkg.sv -----
// ---------------------------------------------------------------------------
// rgbfb_pkg
// Types, register codes and helpers for the RGB framebuffer pixel packer.
// ---------------------------------------------------------------------------
package rgbfb_pkg;

  localparam int LEVEL_W   = 8;
  localparam int WORD_W    = 32;
  localparam int CNT_W     = 6;   // bit count of a 32-bit mask, 0..32
  localparam int RANK_W    = 5;   // index of a bit within the scaled value
  localparam int CFG_IDX_W = 3;
  localparam int NUM_CHAN  = 3;
  localparam int RECIP_W   = 25;
  localparam int PROD_W    = WORD_W + RECIP_W;
  localparam int QUOT_W    = RECIP_W;

  // Largest mask bit count that takes the divide-by-255 scaling
  localparam logic [CNT_W-1:0] SCALE_MAX_BITS = CNT_W'(24);
  // floor((2^32 - 1) / 255); x * RECIP >> 32 is x/255 or one below
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(32'h0101_0101);
  localparam logic [WORD_W-1:0] FULL_LEVEL = WORD_W'(255);

  // Channel slots
  localparam int CH_RED   = 0;
  localparam int CH_GREEN = 1;
  localparam int CH_BLUE  = 2;

  typedef enum logic [1:0] {
    FMT_BGR  = 2'd0,
    FMT_RGB  = 2'd1,
    FMT_MASK = 2'd2,
    FMT_NONE = 2'd3
  } pix_fmt_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_READY      = 3'd0,
    CFG_FORMAT     = 3'd1,
    CFG_RED_MASK   = 3'd2,
    CFG_GREEN_MASK = 3'd3,
    CFG_BLUE_MASK  = 3'd4
  } cfg_reg_t;

  // Population count as eight nibble counts and a short sum
  function automatic logic [CNT_W-1:0] bit_count(input logic [WORD_W-1:0] m);
    logic [CNT_W-1:0] total;
    logic [2:0]       nib;
    total = '0;
    for (int k = 0; k < WORD_W / 4; k++) begin
      nib = {2'b0, m[4*k]} + {2'b0, m[4*k+1]} + {2'b0, m[4*k+2]} + {2'b0, m[4*k+3]};
      total = total + CNT_W'(nib);
    end
    return total;
  endfunction

endpackage

// ----- rtl/rgb_to_framebuffer_pixel_packer_top.sv -----
// ---------------------------------------------------------------------------
// rgb_to_framebuffer_pixel_packer_top
// Packs an 8-bit R/G/B triple into a 32-bit framebuffer pixel word.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel: red_level/green_level/blue_level with in_valid; a word is
//   taken at a clock edge with in_valid high and in_stall low.
//   Output channel: pixel_word with out_valid; taken when out_stall is low.
//   Configuration: cfg_write with cfg_index/cfg_data writes one register
//   (0 ready, 1 format, 2..4 red/green/blue masks). Write only while idle.
//   Path: input register, three work stages, output register. Throughput:
//   one word per clock while out_stall is low.
//   Stages: (v << n) - v, reciprocal multiply by 1/255, quotient correction
//   or wide shift, then bit deposit and format select.
//   Bit counts and deposit ranks of the masks are kept in registers that
//   follow the mask registers each cycle.
//   Reset clears config and valid bits to 0 (display not ready, every pixel 0) and
//   empties the pipeline. When out_stall is high the held word stays put and
//   stages fill up behind it; in_stall rises only once every stage is full.
// ---------------------------------------------------------------------------
`include "rgb_to_framebuffer_pixel_packer_top_defines.svh"

module rgb_to_framebuffer_pixel_packer_top
  import rgbfb_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // configuration
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]    cfg_data,
  // input channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [LEVEL_W-1:0]   red_level,
  input  logic [LEVEL_W-1:0]   green_level,
  input  logic [LEVEL_W-1:0]   blue_level,
  // output channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [WORD_W-1:0]    pixel_word
);

  // Configuration registers
  logic                display_ready;
  pix_fmt_t            pixel_format;
  logic [WORD_W-1:0]   chan_mask [NUM_CHAN];

  // Mask-derived registers, following the masks every cycle
  logic [CNT_W-1:0]    mask_count [NUM_CHAN];
  logic [RANK_W-1:0]   mask_rank  [NUM_CHAN][WORD_W];

  // Pipeline registers
  logic                v1, v2, v3, v4;
  logic [LEVEL_W-1:0]  s1_level [NUM_CHAN];
  logic [LEVEL_W-1:0]  s2_level [NUM_CHAN];
  logic [LEVEL_W-1:0]  s3_level [NUM_CHAN];
  logic [LEVEL_W-1:0]  s4_level [NUM_CHAN];
  logic [WORD_W-1:0]   s2_prod  [NUM_CHAN];   // (v << n) - v
  logic [WORD_W-1:0]   s3_prod  [NUM_CHAN];
  logic [QUOT_W-1:0]   s3_quot  [NUM_CHAN];   // estimate of x / 255
  logic [WORD_W-1:0]   s4_scaled [NUM_CHAN];

  // Stage enables
  logic                en1, en2, en3, en4, en_out;

  // Stage logic
  logic [WORD_W-1:0]   x_next     [NUM_CHAN];
  logic [PROD_W-1:0]   recip_prod [NUM_CHAN];
  logic [WORD_W-1:0]   q255       [NUM_CHAN];
  logic [WORD_W-1:0]   rem_est    [NUM_CHAN];
  logic [QUOT_W-1:0]   quot_fix   [NUM_CHAN];
  logic [WORD_W-1:0]   wide_val   [NUM_CHAN];
  logic [WORD_W-1:0]   scaled_next [NUM_CHAN];
  logic [WORD_W-1:0]   deposit    [NUM_CHAN];
  logic [WORD_W-1:0]   word_next;

  // Handshake: a stage loads when empty or when the next one loads
  assign en_out   = !out_valid || !out_stall;
  assign en4      = !v4 || en_out;
  assign en3      = !v3 || en4;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_stall = !en1;

  // Configuration write port
  always_ff @(posedge clk) begin
    if (rst) begin
      display_ready <= 1'b0;
      pixel_format  <= FMT_BGR;
      for (int c = 0; c < NUM_CHAN; c++) chan_mask[c] <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_READY:      display_ready        <= cfg_data[0];
        CFG_FORMAT:     pixel_format         <= pix_fmt_t'(cfg_data[1:0]);
        CFG_RED_MASK:   chan_mask[CH_RED]    <= cfg_data;
        CFG_GREEN_MASK: chan_mask[CH_GREEN]  <= cfg_data;
        CFG_BLUE_MASK:  chan_mask[CH_BLUE]   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Mask bit counts and per-position deposit ranks
  always_ff @(posedge clk) begin
    for (int c = 0; c < NUM_CHAN; c++) begin
      mask_count[c] <= bit_count(chan_mask[c]);
      for (int i = 0; i < WORD_W; i++) begin
        mask_rank[c][i] <= RANK_W'(bit_count(chan_mask[c] &
                                             ((WORD_W'(1) << i) - WORD_W'(1))));
      end
    end
  end

  // Datapath per channel
  always_comb begin
    for (int c = 0; c < NUM_CHAN; c++) begin
      // v * (2^n - 1), exact for n up to 24
      x_next[c] = ({{(WORD_W-LEVEL_W){1'b0}}, s1_level[c]} << mask_count[c])
                - {{(WORD_W-LEVEL_W){1'b0}}, s1_level[c]};
      // reciprocal multiply
      recip_prod[c] = PROD_W'(s2_prod[c]) * PROD_W'(RECIP);
      // one correction step brings the estimate to floor(x / 255)
      q255[c]     = (WORD_W'(s3_quot[c]) << LEVEL_W) - WORD_W'(s3_quot[c]);
      rem_est[c]  = s3_prod[c] - q255[c];
      quot_fix[c] = s3_quot[c] + QUOT_W'(rem_est[c] >= FULL_LEVEL);
      // more than 24 mask bits: plain left shift
      wide_val[c] = {{(WORD_W-LEVEL_W){1'b0}}, s3_level[c]}
                    << (mask_count[c] - CNT_W'(LEVEL_W));
      scaled_next[c] = (mask_count[c] > SCALE_MAX_BITS) ? wide_val[c]
                                                        : WORD_W'(quot_fix[c]);
      // scatter scaled bits into the set mask positions
      for (int i = 0; i < WORD_W; i++) begin
        deposit[c][i] = chan_mask[c][i] & s4_scaled[c][mask_rank[c][i]];
      end
    end
  end

  // Output format select
  always_comb begin
    word_next = '0;
    if (display_ready) begin
      unique case (pixel_format)
        FMT_BGR:  word_next = {8'b0, s4_level[CH_BLUE], s4_level[CH_GREEN],
                               s4_level[CH_RED]};
        FMT_RGB:  word_next = {8'b0, s4_level[CH_RED], s4_level[CH_GREEN],
                               s4_level[CH_BLUE]};
        FMT_MASK: word_next = deposit[CH_RED] | deposit[CH_GREEN] | deposit[CH_BLUE];
        FMT_NONE: word_next = '0;
      endcase
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en1)    v1        <= in_valid;
      if (en2)    v2        <= v1;
      if (en3)    v3        <= v2;
      if (en4)    v4        <= v3;
      if (en_out) out_valid <= v4;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (en1) begin
      s1_level[CH_RED]   <= red_level;
      s1_level[CH_GREEN] <= green_level;
      s1_level[CH_BLUE]  <= blue_level;
    end
    for (int c = 0; c < NUM_CHAN; c++) begin
      if (en2) begin
        s2_level[c] <= s1_level[c];
        s2_prod[c]  <= x_next[c];
      end
      if (en3) begin
        s3_level[c] <= s2_level[c];
        s3_prod[c]  <= s2_prod[c];
        s3_quot[c]  <= recip_prod[c][PROD_W-1:WORD_W];
      end
      if (en4) begin
        s4_level[c]  <= s3_level[c];
        s4_scaled[c] <= scaled_next[c];
      end
    end
    if (en_out) pixel_word <= word_next;
  end

  // Checks
  `RFP_ASSERT_IMPL(a_not_ready_zero, clk, rst, out_valid && !display_ready, pixel_word == '0)
  `RFP_ASSERT_IMPL(a_unsup_zero, clk, rst, out_valid && pixel_format == FMT_NONE, pixel_word == '0)
  `RFP_ASSERT_IMPL(a_byte_top_zero, clk, rst, out_valid && (pixel_format == FMT_BGR || pixel_format == FMT_RGB), pixel_word[31:24] == 8'b0)
  `RFP_ASSERT_IMPL(a_quot_est, clk, rst, v3, (mask_count[0] > SCALE_MAX_BITS || rem_est[0] < 2 * FULL_LEVEL) && (mask_count[1] > SCALE_MAX_BITS || rem_est[1] < 2 * FULL_LEVEL) && (mask_count[2] > SCALE_MAX_BITS || rem_est[2] < 2 * FULL_LEVEL))
  `RFP_ASSERT_NEXT(a_drain, clk, rst, v4 && en_out, out_valid)

endmodule
